// File: hw/rtl/cls_pkg.sv
// Shared widths and constants for the CPU load sampler.
`timescale 1ns / 1ps

package cls_pkg;

    localparam int DATA_W         = 32;
    localparam int CPU_W          = 8;
    localparam int CORE_COUNT_DEF = 4;

    localparam logic [DATA_W-1:0] MIN_WINDOW_RST = 32'd1000000;

endpackage

// File: hw/rtl/cls_div.sv
// Radix-2 restoring divider: (dividend << 32) / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module cls_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [cls_pkg::DATA_W-1:0] dividend,
    input  logic [cls_pkg::DATA_W-1:0] divisor,
    output logic                      done,
    output logic [cls_pkg::DATA_W-1:0] quotient
);
    import cls_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W-1:0] quo_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              q_bit;

    // Caller guarantees dividend < divisor, so the remainder stays below divisor.
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign q_bit   = ~diff[DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/cpu_load_sampler_unit.sv
// CPU load sampler: per-core busy share from idle time and timestamps.
// Usage:
//   Config: cfg_wr_en with cfg_wr_data writes min_window; write only while idle.
//   Input channel (in_valid/in_stall): cpu, source_ok, now, idle_total,
//   idle_running, idle_slice_start. One transaction in, one load out.
//   Output channel (out_valid/out_stall): load, held in an output register,
//   so the next request is taken while a result still waits.
// Flow:
//   Invalid core or no source: straight to DONE with a load of zero.
//   Sample inside min_window (stored load reused): LOOKUP, EVAL, DONE.
//   New measurement without division: LOOKUP, EVAL, WRITE, DONE.
//   New measurement with division: table read (LOOKUP), evaluate (EVAL), the
//   radix-2 divider (DIV), write-back (WRITE) and DONE.
//   One request is in flight at a time; in_stall is high while it works,
//   so a new request is taken only once the current one has left DONE.
// Reset clears the per-core valid bits (all cores read as never sampled,
// zero idle and zero load) and loads min_window with 1000000.
// A stalled receiver holds load; the block finishes its current request and
// waits with the next result until the output register frees.
`timescale 1ns / 1ps

module cpu_load_sampler_unit #(
    parameter int CORE_COUNT = cls_pkg::CORE_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cls_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [cls_pkg::CPU_W-1:0]  cpu,
    input  logic                       source_ok,
    input  logic [cls_pkg::DATA_W-1:0] now,
    input  logic [cls_pkg::DATA_W-1:0] idle_total,
    input  logic                       idle_running,
    input  logic [cls_pkg::DATA_W-1:0] idle_slice_start,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [cls_pkg::DATA_W-1:0] load
);
    import cls_pkg::*;

    localparam int IDX_W   = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam int ENTRY_W = 3 * DATA_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_LOOKUP = 6'b000010,
        S_EVAL   = 6'b000100,
        S_DIV    = 6'b001000,
        S_WRITE  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [DATA_W-1:0]     min_window_reg;
    logic [CORE_COUNT-1:0] valid_reg;
    logic                  hit_reg;
    logic                  out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DATA_W-1:0] now_reg, now_next;
    logic [DATA_W-1:0] idle_tot_reg, idle_tot_next;
    logic              running_reg, running_next;
    logic [DATA_W-1:0] slice_reg, slice_next;
    logic [DATA_W-1:0] idle_now_reg, idle_now_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0] load_reg, load_next;

    logic [ENTRY_W-1:0] mem [CORE_COUNT];
    logic [ENTRY_W-1:0] rd_reg;

    logic              accept;
    logic              in_range;
    logic              mem_we;
    logic [DATA_W-1:0] ent_idle, ent_stamp, ent_load;
    logic              sampled;
    logic [DATA_W-1:0] window;
    logic [DATA_W-1:0] idle_delta;
    logic              reuse;
    logic              need_div;
    logic              div_start;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign in_range = ({1'b0, cpu} < (CPU_W + 1)'(CORE_COUNT));
    assign mem_we   = (state_reg == S_WRITE);

    // Entry fields; a core never written reads as all zero.
    assign ent_idle   = hit_reg ? rd_reg[3*DATA_W-1:2*DATA_W] : '0;
    assign ent_stamp  = hit_reg ? rd_reg[2*DATA_W-1:DATA_W]   : '0;
    assign ent_load   = hit_reg ? rd_reg[DATA_W-1:0]          : '0;
    assign sampled    = (ent_stamp != '0);
    assign window     = now_reg - ent_stamp;
    assign idle_delta = idle_now_reg - ent_idle;
    assign reuse      = sampled && (window < min_window_reg);
    assign need_div   = sampled && (window != '0) && (idle_delta < window);
    assign div_start  = (state_reg == S_EVAL) && !reuse && need_div;

    cls_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (idle_delta),
        .divisor  (window),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        idx_next       = idx_reg;
        now_next       = now_reg;
        idle_tot_next  = idle_tot_reg;
        running_next   = running_reg;
        slice_next     = slice_reg;
        idle_now_next  = idle_now_reg;
        res_next       = res_reg;
        load_next      = load_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next      = cpu[IDX_W-1:0];
                    now_next      = now;
                    idle_tot_next = idle_total;
                    running_next  = idle_running;
                    slice_next    = idle_slice_start;
                    if (!in_range || !source_ok)
                    begin
                        res_next   = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP:
            begin
                // Fold in the idle slice still running.
                idle_now_next = idle_tot_reg + (running_reg ? (now_reg - slice_reg) : '0);
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                if (reuse)
                begin
                    res_next   = ent_load;
                    state_next = S_DONE;
                end
                else if (need_div)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    res_next   = '0;
                    state_next = S_WRITE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = ~div_quo;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    load_next      = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            min_window_reg <= MIN_WINDOW_RST;
            valid_reg      <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= valid_reg[idx_reg];
            if (cfg_wr_en)
            begin
                min_window_reg <= cfg_wr_data;
            end
            if (mem_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        now_reg      <= now_next;
        idle_tot_reg <= idle_tot_next;
        running_reg  <= running_next;
        slice_reg    <= slice_next;
        idle_now_reg <= idle_now_next;
        res_reg      <= res_next;
        load_reg     <= load_next;
    end

    // Per-core table: idle total, stamp, load.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= {idle_now_reg, now_reg, res_reg};
        end
        rd_reg <= mem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign load      = load_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide state");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> valid_reg[$past(idx_reg)])
        else $error("table write did not mark the core as valid");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && !out_valid_reg) |=> (out_valid_reg && (load_reg == $past(res_reg))))
        else $error("finished result not moved to the output register");

endmodule

// File: dv/cls_load_checker.sv
// Load sampler checker: watches both channels, predicts each load and compares it.
`timescale 1ns / 1ps

module cls_load_checker #(
    parameter int CORE_COUNT = cls_pkg::CORE_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [cls_pkg::DATA_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [cls_pkg::CPU_W-1:0]  cpu,
    input  logic                       source_ok,
    input  logic [cls_pkg::DATA_W-1:0] now,
    input  logic [cls_pkg::DATA_W-1:0] idle_total,
    input  logic                       idle_running,
    input  logic [cls_pkg::DATA_W-1:0] idle_slice_start,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [cls_pkg::DATA_W-1:0] load,
    output int                         errors,
    output int                         pending
);

    import cls_pkg::*;

    typedef logic [DATA_W-1:0] word_t;

    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic             source_ok;
        word_t            now;
        word_t            idle_total;
        logic             idle_running;
        word_t            idle_slice_start;
    } sample_req_t;

    word_t window_min;
    word_t core_idle  [CORE_COUNT];
    word_t core_stamp [CORE_COUNT];
    word_t core_load  [CORE_COUNT];
    word_t load_q[$];

    // Busy share of one request; updates the per-core history when it measures.
    function automatic word_t measure_load(sample_req_t r);
        word_t       span;
        word_t       idle_now;
        word_t       idle_span;
        word_t       busy;
        logic [63:0] quot;
        busy = '0;
        if (r.cpu >= CORE_COUNT || !r.source_ok)
            return '0;
        span = r.now - core_stamp[r.cpu];
        // stamp of zero reads as never sampled
        if (core_stamp[r.cpu] != '0 && span < window_min)
            return core_load[r.cpu];
        idle_now = r.idle_total;
        if (r.idle_running)
            idle_now = idle_now + (r.now - r.idle_slice_start);
        if (core_stamp[r.cpu] != '0 && span != '0)
        begin
            idle_span = idle_now - core_idle[r.cpu];
            if (idle_span < span)
            begin
                quot = {idle_span, 32'd0} / {32'd0, span};
                busy = 32'hFFFF_FFFF - quot[31:0];
            end
        end
        core_idle[r.cpu]  = idle_now;
        core_stamp[r.cpu] = r.now;
        core_load[r.cpu]  = busy;
        return busy;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            window_min = MIN_WINDOW_RST;
            for (int i = 0; i < CORE_COUNT; i++)
            begin
                core_idle[i]  = '0;
                core_stamp[i] = '0;
                core_load[i]  = '0;
            end
            load_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                window_min = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (load_q.size() == 0)
                begin
                    $error("load: unexpected transaction, expected none, actual %h", load);
                    errors++;
                end
                else
                begin
                    want = load_q.pop_front();
                    if (load !== want)
                    begin
                        $error("load mismatch: expected %h, actual %h", want, load);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                load_q.push_back(measure_load('{cpu, source_ok, now, idle_total,
                                                idle_running, idle_slice_start}));
            pending = load_q.size();
        end
    end

endmodule

// File: dv/cpu_load_sampler_unit_tb.sv
// Testbench top for the CPU load sampler: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module cpu_load_sampler_unit_tb;

    import cls_pkg::*;

    localparam int CORE_COUNT   = CORE_COUNT_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 210;

    typedef logic [DATA_W-1:0] word_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    word_t            cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    logic [CPU_W-1:0] cpu;
    logic             source_ok;
    word_t            now;
    word_t            idle_total;
    logic             idle_running;
    word_t            idle_slice_start;
    logic             out_valid;
    logic             out_stall;
    word_t            load;

    int    fail_count;
    int    pending;
    bit    quiet;
    word_t cur_window;
    word_t core_clock [CORE_COUNT];
    word_t core_idle  [CORE_COUNT];

    cpu_load_sampler_unit #(
        .CORE_COUNT (CORE_COUNT)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cpu              (cpu),
        .source_ok        (source_ok),
        .now              (now),
        .idle_total       (idle_total),
        .idle_running     (idle_running),
        .idle_slice_start (idle_slice_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .load             (load)
    );

    cls_load_checker #(
        .CORE_COUNT (CORE_COUNT)
    ) u_load_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cpu              (cpu),
        .source_ok        (source_ok),
        .now              (now),
        .idle_total       (idle_total),
        .idle_running     (idle_running),
        .idle_slice_start (idle_slice_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .load             (load),
        .errors           (fail_count),
        .pending          (pending)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver back-pressure in random bursts
    always
    begin
        @(posedge clk);
        if (!quiet && rst_n && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clk);
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_req(input logic [CPU_W-1:0] c, input logic ok, input word_t t,
                            input word_t idl, input logic run, input word_t slice);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        cpu              <= c;
        source_ok        <= ok;
        now              <= t;
        idle_total       <= idl;
        idle_running     <= run;
        idle_slice_start <= slice;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input word_t w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_window  = w;
    endtask

    // Advance one core's clock and idle counter, then sample it.
    task automatic send_tracked(input int c, input logic ok);
        word_t delta;
        word_t inc;
        word_t part;
        logic  run;
        case ($urandom_range(0, 4))
            0: delta = $urandom_range(0, 3000);
            1: delta = cur_window + $urandom_range(0, 4) - 2;
            2: delta = cur_window + $urandom_range(0, 1_000_000);
            3: delta = $urandom_range(1, 50_000_000);
            default: delta = $urandom();
        endcase
        // idle share mostly below the window, sometimes above
        inc  = word_t'((64'(delta) * $urandom_range(0, 1100)) / 1000);
        run  = $urandom_range(0, 1);
        part = run ? word_t'($urandom_range(0, inc)) : '0;
        core_clock[c] = core_clock[c] + delta;
        core_idle[c]  = core_idle[c] + inc;
        send_req(CPU_W'(c), ok, core_clock[c], core_idle[c] - part, run,
                 core_clock[c] - part);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            send_tracked($urandom_range(0, CORE_COUNT - 1), 1'b1);
        else if (pick < 90)
            send_tracked($urandom_range(0, CORE_COUNT - 1), 1'b0);
        else if (pick < 94)
            send_req(CPU_W'($urandom_range(CORE_COUNT, 255)), 1'($urandom), $urandom,
                     $urandom, 1'($urandom), $urandom);
        else
            send_req(CPU_W'($urandom), 1'($urandom), $urandom, $urandom,
                     1'($urandom), $urandom);
    endtask

    initial
    begin
        word_t windows[6];
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        in_valid         <= 1'b0;
        cpu              <= '0;
        source_ok        <= 1'b0;
        now              <= '0;
        idle_total       <= '0;
        idle_running     <= 1'b0;
        idle_slice_start <= '0;
        quiet            = 1'b0;
        cur_window       = MIN_WINDOW_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // out of range core and missing source
        send_req(8'hFF, 1'b1, '1, '1, 1'b1, '1);
        send_req(CPU_W'(CORE_COUNT), 1'b1, 32'd5_000_000, '0, 1'b0, '0);
        send_req(8'd0, 1'b0, 32'd5_000_000, '0, 1'b0, '0);
        // first sample, reuse inside window, then real measurements
        send_req(8'd0, 1'b1, 32'd1000, '0, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd2000, 32'd10, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd2_001_000, 32'd500_000, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd2_001_500, 32'd600_000, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd6_001_000, 32'd900_000, 1'b1, 32'd5_001_000);
        // stamp zero leaves the core looking unsampled
        send_req(8'd1, 1'b1, '0, 32'd77, 1'b0, '0);
        send_req(8'd1, 1'b1, 32'd3_000_000, 32'd1_000_000, 1'b0, '0);
        // idle equal to and above the window
        send_req(8'd1, 1'b1, 32'd5_000_000, 32'd3_000_000, 1'b0, '0);
        send_req(8'd1, 1'b1, 32'd7_000_000, 32'hFFFF_0000, 1'b0, '0);
        // timestamp wrap
        send_req(8'd2, 1'b1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, '0);
        send_req(8'd2, 1'b1, 32'h0020_0000, 32'h0001_0000, 1'b0, '0);
        send_req(8'd3, 1'b1, 32'h8000_0000, '0, 1'b1, 32'h8000_0000);
        send_req(8'd3, 1'b1, 32'hFFFF_FFFF, '0, 1'b1, '0);
        drain();

        // zero window, then fully busy
        set_window('0);
        send_req(8'd0, 1'b1, 32'd6_001_000, 32'd900_000, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd9_001_000, 32'd900_000, 1'b0, '0);
        drain();

        // largest window: only a span of all ones measures
        set_window('1);
        send_req(8'd0, 1'b1, 32'd9_001_000 + 32'hFFFF_FFFE, 32'd900_003, 1'b0, '0);
        send_req(8'd0, 1'b1, 32'd9_000_999, 32'd900_005, 1'b0, '0);
        drain();

        for (int i = 0; i < CORE_COUNT; i++)
        begin
            core_clock[i] = $urandom();
            core_idle[i]  = $urandom();
        end

        windows = '{32'd0, 32'd1, 32'd5000, word_t'($urandom_range(1, 2_000_000)),
                    32'hFFFF_FFFF, 32'd1_000_000};
        foreach (windows[p])
        begin
            drain();
            set_window(windows[p]);
            if (p == 5)
                quiet = 1'b1;
            repeat (PHASE_ITEMS) random_item();
        end
        drain();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: cpu_load_sampler_unit.f
hw/rtl/cls_pkg.sv
hw/rtl/cls_div.sv
hw/rtl/cpu_load_sampler_unit.sv
dv/cls_load_checker.sv
dv/cpu_load_sampler_unit_tb.sv
